// ----- src/eic_pkg.sv -----
// Shared types and constants of the external interrupt controller.
package eic_pkg;

    localparam int unsigned LINES     = 8;
    localparam int unsigned SENSE_W   = 2;
    localparam int unsigned LINE_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0]
    {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_ACK   = 2'd3
    } mode_t;

    typedef enum logic [SENSE_W-1:0]
    {
        SENSE_LOW    = 2'd0,
        SENSE_CHANGE = 2'd1,
        SENSE_FALL   = 2'd2,
        SENSE_RISE   = 2'd3
    } sense_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_SENSE_LOW  = 2'd0,
        CFG_SENSE_HIGH = 2'd1,
        CFG_UNUSED_2   = 2'd2,
        CFG_UNUSED_3   = 2'd3
    } cfg_index_t;

    typedef enum logic
    {
        SEL_MASK  = 1'b0,
        SEL_FLAGS = 1'b1
    } reg_select_t;

endpackage

// ----- src/external_interrupt_controller.sv -----
// External interrupt controller: eight lines, programmable sense, mask and flags.
//
// Takes one request per clock cycle while in_ready is high. Each request is
// captured in an input register and then, when the result register can
// advance, applied to the mask, flag and previous-pin state while its result
// (read data and mask AND flags) is loaded into the result register. in_ready
// drops only while both the input register and the result register are full
// and the result is not being taken. Sense registers are written through the
// configuration port, which is always ready.
module external_interrupt_controller
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [7:0]                      pin_levels,
    input  logic                            reg_select,
    input  logic [7:0]                      write_data,
    input  logic [eic_pkg::LINE_W-1:0]      ack_line,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      read_data,
    output logic [7:0]                      irq_pending,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [eic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import eic_pkg::*;

    logic [7:0]              sense_low_reg;
    logic [7:0]              sense_high_reg;
    logic [LINES-1:0]        mask_reg;
    logic [LINES-1:0]        mask_next;
    logic [LINES-1:0]        flags_reg;
    logic [LINES-1:0]        flags_next;
    logic [LINES-1:0]        prev_pins_reg;
    logic [LINES-1:0]        prev_pins_next;

    logic                    s1_valid_reg;
    mode_t                   s1_mode_reg;
    logic [LINES-1:0]        s1_pins_reg;
    reg_select_t             s1_sel_reg;
    logic [7:0]              s1_data_reg;
    logic [LINE_W-1:0]       s1_ack_reg;

    logic                    out_valid_reg;
    logic [7:0]              read_data_reg;
    logic [7:0]              read_data_next;
    logic [LINES-1:0]        irq_reg;

    logic                    advance;
    logic                    in_fire;
    logic [2*LINES-1:0]      sense_all;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign sense_all = {sense_high_reg, sense_low_reg};

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign irq_pending = irq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_low_reg  <= '0;
            sense_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SENSE_LOW:  sense_low_reg  <= cfg_data;
                CFG_SENSE_HIGH: sense_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg <= mode_t'(mode);
            s1_pins_reg <= pin_levels;
            s1_sel_reg  <= reg_select_t'(reg_select);
            s1_data_reg <= write_data;
            s1_ack_reg  <= ack_line;
        end
    end

    always_comb
    begin
        sense_t sense;
        logic   now;
        logic   prev;
        sense          = SENSE_LOW;
        now            = 1'b0;
        prev           = 1'b0;
        mask_next      = mask_reg;
        flags_next     = flags_reg;
        prev_pins_next = prev_pins_reg;
        read_data_next = '0;
        unique case (s1_mode_reg)
            MODE_TICK:
            begin
                for (int k = 0; k < LINES; k++)
                begin
                    sense = sense_t'(sense_all[SENSE_W*k +: SENSE_W]);
                    now   = s1_pins_reg[k];
                    prev  = prev_pins_reg[k];
                    unique case (sense)
                        SENSE_LOW:    flags_next[k] = !now;
                        SENSE_CHANGE: flags_next[k] = flags_reg[k] | (now ^ prev);
                        SENSE_FALL:   flags_next[k] = flags_reg[k] | (!now && prev);
                        SENSE_RISE:   flags_next[k] = flags_reg[k] | (now && !prev);
                        default:      flags_next[k] = flags_reg[k];
                    endcase
                end
                prev_pins_next = s1_pins_reg;
            end
            MODE_WRITE:
            begin
                if (s1_sel_reg == SEL_MASK)
                    mask_next = s1_data_reg;
                else
                    flags_next = flags_reg & ~s1_data_reg;
            end
            MODE_READ:
            begin
                read_data_next = (s1_sel_reg == SEL_MASK) ? mask_reg : flags_reg;
            end
            MODE_ACK:
            begin
                flags_next[s1_ack_reg] = 1'b0;
            end
            default: ;
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            flags_reg     <= '0;
            prev_pins_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                mask_reg      <= mask_next;
                flags_reg     <= flags_next;
                prev_pins_reg <= prev_pins_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= mask_next & flags_next;
        end
    end

endmodule

// ----- src/eic_checker.sv -----
// Port-level checker of the external interrupt controller and its bind.
module eic_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic [7:0] irq_pending,
    input logic       cfg_ready
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq_pending))
        else $error("stalled result changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a request two cycles before");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind external_interrupt_controller eic_checker u_eic_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .irq_pending (irq_pending),
    .cfg_ready   (cfg_ready)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the eight-line external interrupt controller.
`timescale 1ns / 100ps

module tb;
    import eic_pkg::*;

    typedef struct packed
    {
        mode_t              mode;
        logic [7:0]         pins;
        reg_select_t        sel;
        logic [7:0]         data;
        logic [LINE_W-1:0]  ack;
    } eic_request_t;

    typedef struct packed
    {
        logic [7:0] read_data;
        logic [7:0] irq_pending;
    } eic_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             mode = 2'd0;
    logic [7:0]             pin_levels = 8'd0;
    logic                   reg_select = 1'b0;
    logic [7:0]             write_data = 8'd0;
    logic [LINE_W-1:0]      ack_line = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             read_data;
    logic [7:0]             irq_pending;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [7:0]             cfg_data = 8'd0;

    eic_request_t   eic_requests[$];
    eic_outcome_t   predicted_outputs[$];

    logic [15:0]    shadow_sense = 16'd0;
    logic [7:0]     shadow_mask = 8'd0;
    logic [7:0]     shadow_flags = 8'd0;
    logic [7:0]     shadow_pins = 8'd0;

    int             in_idle_pct = 0;
    int             out_idle_pct = 0;
    int             in_gap = 0;
    int             out_gap = 0;
    int             error_count = 0;
    eic_request_t   next_request;
    eic_outcome_t   monitor_want;

    external_interrupt_controller u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .pin_levels  (pin_levels),
        .reg_select  (reg_select),
        .write_data  (write_data),
        .ack_line    (ack_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .irq_pending (irq_pending),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic eic_outcome_t advance_controller(eic_request_t r);
        eic_outcome_t o;
        sense_t       s;
        o.read_data = 8'd0;
        case (r.mode)
            MODE_TICK:
            begin
                for (int k = 0; k < LINES; k++)
                begin
                    s = sense_t'(shadow_sense[2*k +: 2]);
                    case (s)
                        SENSE_LOW:    shadow_flags[k] = ~r.pins[k];
                        SENSE_CHANGE: if (r.pins[k] != shadow_pins[k]) shadow_flags[k] = 1'b1;
                        SENSE_FALL:   if (!r.pins[k] && shadow_pins[k]) shadow_flags[k] = 1'b1;
                        SENSE_RISE:   if (r.pins[k] && !shadow_pins[k]) shadow_flags[k] = 1'b1;
                    endcase
                end
                shadow_pins = r.pins;
            end
            MODE_WRITE:
            begin
                if (r.sel == SEL_MASK)
                    shadow_mask = r.data;
                else
                    shadow_flags = shadow_flags & ~r.data;
            end
            MODE_READ:
                o.read_data = (r.sel == SEL_MASK) ? shadow_mask : shadow_flags;
            MODE_ACK:
                shadow_flags[r.ack] = 1'b0;
        endcase
        o.irq_pending = shadow_mask & shadow_flags;
        return o;
    endfunction

    function automatic void queue_request(mode_t m, logic [7:0] p, reg_select_t s,
                                          logic [7:0] d, logic [LINE_W-1:0] a);
        eic_request_t r;
        r.mode = m;
        r.pins = p;
        r.sel  = s;
        r.data = d;
        r.ack  = a;
        eic_requests = {eic_requests, r};
    endfunction

    task automatic write_sense(input cfg_index_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SENSE_LOW:  shadow_sense[7:0]  = value;
            CFG_SENSE_HIGH: shadow_sense[15:8] = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (eic_requests.size() != 0 || in_valid || predicted_outputs.size() != 0);
    endtask

    // driver: hold each request until accepted, insert idle bursts between requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= MODE_TICK;
            pin_levels <= 8'd0;
            reg_select <= SEL_MASK;
            write_data <= 8'd0;
            ack_line   <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                next_request.mode = mode_t'(mode);
                next_request.pins = pin_levels;
                next_request.sel  = reg_select_t'(reg_select);
                next_request.data = write_data;
                next_request.ack  = ack_line;
                predicted_outputs = {predicted_outputs, advance_controller(next_request)};
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (eic_requests.size() == 0)
                    in_valid <= 1'b0;
                else if ($urandom_range(99) < in_idle_pct)
                begin
                    in_gap = $urandom_range(12, 1) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_request = eic_requests.pop_front();
                    in_valid   <= 1'b1;
                    mode       <= next_request.mode;
                    pin_levels <= next_request.pins;
                    reg_select <= next_request.sel;
                    write_data <= next_request.data;
                    ack_line   <= next_request.ack;
                end
            end
        end
    end

    // monitor: check each result against the oldest prediction, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $error("result with no request outstanding: read_data %0h irq_pending %0h",
                           read_data, irq_pending);
                    error_count++;
                end
                else
                begin
                    monitor_want = predicted_outputs.pop_front();
                    if (read_data !== monitor_want.read_data)
                    begin
                        $error("read_data: expected %0h actual %0h",
                               monitor_want.read_data, read_data);
                        error_count++;
                    end
                    if (irq_pending !== monitor_want.irq_pending)
                    begin
                        $error("irq_pending: expected %0h actual %0h",
                               monitor_want.irq_pending, irq_pending);
                        error_count++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99) < out_idle_pct)
            begin
                out_gap = $urandom_range(12, 1) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0] last_pins;
        int         pick;
        logic [7:0] lo_sense;
        logic [7:0] hi_sense;
        last_pins = 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // one line per sense mode in each half
        write_sense(CFG_SENSE_LOW, 8'hE4);
        write_sense(CFG_SENSE_HIGH, 8'hE4);
        write_sense(CFG_UNUSED_2, 8'hFF);
        write_sense(CFG_UNUSED_3, 8'h00);
        in_idle_pct  = 25;
        out_idle_pct = 25;
        @(negedge clk);
        queue_request(MODE_WRITE, 8'hFF, SEL_MASK,  8'hFF, 3'd7);
        queue_request(MODE_READ,  8'hFF, SEL_MASK,  8'h00, 3'd0);
        queue_request(MODE_TICK,  8'hFF, SEL_FLAGS, 8'hFF, 3'd7);
        queue_request(MODE_READ,  8'h00, SEL_FLAGS, 8'hFF, 3'd0);
        queue_request(MODE_TICK,  8'h00, SEL_MASK,  8'h00, 3'd0);
        queue_request(MODE_TICK,  8'h00, SEL_FLAGS, 8'hFF, 3'd7);
        queue_request(MODE_TICK,  8'h11, SEL_MASK,  8'h00, 3'd0);
        queue_request(MODE_READ,  8'hFF, SEL_FLAGS, 8'h00, 3'd7);
        queue_request(MODE_WRITE, 8'hFF, SEL_FLAGS, 8'h0F, 3'd0);
        queue_request(MODE_TICK,  8'hFF, SEL_MASK,  8'h00, 3'd0);
        queue_request(MODE_ACK,   8'h00, SEL_FLAGS, 8'hFF, 3'd0);
        queue_request(MODE_ACK,   8'hFF, SEL_MASK,  8'h00, 3'd7);
        queue_request(MODE_ACK,   8'h00, SEL_MASK,  8'h00, 3'd3);
        queue_request(MODE_WRITE, 8'h00, SEL_FLAGS, 8'hFF, 3'd5);
        queue_request(MODE_TICK,  8'hAA, SEL_FLAGS, 8'h00, 3'd2);
        queue_request(MODE_TICK,  8'h55, SEL_MASK,  8'hFF, 3'd6);
        queue_request(MODE_WRITE, 8'hFF, SEL_MASK,  8'h00, 3'd1);
        queue_request(MODE_READ,  8'h00, SEL_FLAGS, 8'h00, 3'd4);
        queue_request(MODE_WRITE, 8'h00, SEL_MASK,  8'hA5, 3'd0);
        queue_request(MODE_TICK,  8'h00, SEL_FLAGS, 8'h5A, 3'd7);
        queue_request(MODE_READ,  8'hFF, SEL_MASK,  8'hFF, 3'd7);
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin lo_sense = 8'h00; hi_sense = 8'h00; end
                1:       begin lo_sense = 8'hFF; hi_sense = 8'hFF; end
                2:       begin lo_sense = 8'h55; hi_sense = 8'hAA; end
                3:       begin lo_sense = 8'hAA; hi_sense = 8'h55; end
                default:
                begin
                    lo_sense = 8'($urandom_range(255));
                    hi_sense = 8'($urandom_range(255));
                end
            endcase
            if (phase % 3 == 0)
                write_sense($urandom_range(1) ? CFG_UNUSED_3 : CFG_UNUSED_2,
                            8'($urandom_range(255)));
            write_sense(CFG_SENSE_LOW, lo_sense);
            write_sense(CFG_SENSE_HIGH, hi_sense);
            if (phase == 2 || phase == 7)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct  = $urandom_range(40, 5);
                out_idle_pct = $urandom_range(40, 5);
            end
            @(negedge clk);
            for (int n = 0; n < 240; n++)
            begin
                pick = $urandom_range(99);
                if ($urandom_range(3) != 0)
                    last_pins = 8'($urandom_range(255));
                if (pick < 45)
                    queue_request(MODE_TICK, last_pins, reg_select_t'($urandom_range(1)),
                                  8'($urandom_range(255)), 3'($urandom_range(7)));
                else if (pick < 65)
                    queue_request(MODE_WRITE, 8'($urandom_range(255)),
                                  reg_select_t'($urandom_range(1)),
                                  8'($urandom_range(255) & $urandom_range(255)),
                                  3'($urandom_range(7)));
                else if (pick < 85)
                    queue_request(MODE_READ, 8'($urandom_range(255)),
                                  reg_select_t'($urandom_range(1)),
                                  8'($urandom_range(255)), 3'($urandom_range(7)));
                else
                    queue_request(MODE_ACK, 8'($urandom_range(255)),
                                  reg_select_t'($urandom_range(1)),
                                  8'($urandom_range(255)), 3'($urandom_range(7)));
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0 && predicted_outputs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
